/* src/gbba_pkg.sv */
`timescale 1ns / 1ps

package gbba_pkg;

  localparam int GROUPS_DEF = 8;
  localparam int BLOCKS_PER_GROUP_DEF = 256;

  localparam int PG_W    = 4;
  localparam int BLKIN_W = 12;
  localparam int BLK_W   = 11;
  localparam int CNT_W   = 9;
  localparam int TOTAL_W = 12;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_NO_SPACE     = 3'd1,
    ST_BAD_GROUP    = 3'd2,
    ST_OUT_OF_RANGE = 3'd3,
    ST_CORRUPT      = 3'd4
  } status_t;

endpackage

/* src/grouped_block_bitmap_allocator_unit.sv */
`timescale 1ns / 1ps

// channel   signals                                            direction
// request   start, busy, req_type, preferred_group, target_blk in (busy out)
// result    done, status, granted_blk                          out
//
// One request at a time; accepted when start is high and busy is low.
// Bad group, no space, free of block zero or out of range: result in the next cycle.
// Allocate hitting the preferred group: row read on acceptance, then S_EVAL; a preferred
// group with no room is skipped unread, S_SCAN going to the first group with room; each
// further group row tried: S_SCAN reads it, S_EVAL encodes and writes back. Free: S_DEC, S_EVAL.
// Synchronous reset; row and count memories read as their reset contents
// until first written, so no clearing pass. The receiver cannot stall.

module grouped_block_bitmap_allocator_unit #(
  parameter int GROUPS = gbba_pkg::GROUPS_DEF,
  parameter int BLOCKS_PER_GROUP = gbba_pkg::BLOCKS_PER_GROUP_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          req_type,
  input  logic [gbba_pkg::PG_W-1:0]     preferred_group,
  input  logic [gbba_pkg::BLKIN_W-1:0]  target_blk,
  output logic                          done,
  output gbba_pkg::status_t             status,
  output logic [gbba_pkg::BLK_W-1:0]    granted_blk
);
  import gbba_pkg::*;

  localparam int GW    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int IW    = $clog2(BLOCKS_PER_GROUP);
  localparam int TOTAL = GROUPS * BLOCKS_PER_GROUP;
  localparam logic [PG_W:0]      GROUPS_V = (PG_W+1)'(GROUPS);
  localparam logic [BLKIN_W:0]   TOTAL_V  = (BLKIN_W+1)'(TOTAL);
  localparam logic [CNT_W-1:0]   CNT_MAX  = '1;
  localparam logic [TOTAL_W-1:0] TOT_MAX  = '1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DEC  = 4'b0010,
    S_SCAN = 4'b0100,
    S_EVAL = 4'b1000
  } state_t;

  state_t state;

  logic [BLOCKS_PER_GROUP-1:0] row_mem [GROUPS];
  logic [CNT_W-1:0]            cnt_mem [GROUPS];
  logic [BLOCKS_PER_GROUP-1:0] rd_row;
  logic [CNT_W-1:0]            rd_cnt;
  logic                        rd_valid;
  logic [GROUPS-1:0]           rvalid;
  logic [GROUPS-1:0]           room;
  logic [GROUPS-1:0]           cand;
  logic [TOTAL_W-1:0]          total_free;
  logic                        op;
  logic                        fallback;
  logic [GW-1:0]               cur;
  logic [IW-1:0]               idx;
  logic [BLKIN_W-1:0]          bn;

  logic                        rd_en;
  logic [GW-1:0]               rd_addr;
  logic                        we;
  logic [BLOCKS_PER_GROUP-1:0] row_eff;
  logic [CNT_W-1:0]            cnt_eff;
  logic [BLOCKS_PER_GROUP-1:0] wr_row;
  logic [CNT_W-1:0]            wr_cnt;
  logic                        free_hit;
  logic [IW-1:0]               free_idx;
  logic                        cand_hit;
  logic [GW-1:0]               cand_g;
  logic [GW-1:0]               dec_g;
  logic [IW-1:0]               dec_i;
  logic [BLKIN_W-1:0]          dec_base;
  logic [BLKIN_W-1:0]          blk_full;
  logic                        pg_ok;
  logic [GW-1:0]               pg_idx;

  assign busy   = (state != S_IDLE);
  assign pg_ok  = ({1'b0, preferred_group} < GROUPS_V);
  assign pg_idx = GW'(preferred_group);

  assign row_eff = rd_valid ? rd_row :
                   ((cur == '0) ? BLOCKS_PER_GROUP'(1) : '0);
  assign cnt_eff = rd_valid ? rd_cnt :
                   ((cur == '0) ? CNT_W'(BLOCKS_PER_GROUP - 1) : CNT_W'(BLOCKS_PER_GROUP));

  always_comb begin
    free_hit = 1'b0;
    free_idx = '0;
    for (int k = BLOCKS_PER_GROUP - 1; k >= 0; k--) begin
      if (!row_eff[k]) begin
        free_hit = 1'b1;
        free_idx = IW'(k);
      end
    end
  end

  always_comb begin
    cand_hit = 1'b0;
    cand_g   = '0;
    for (int k = GROUPS - 1; k >= 0; k--) begin
      if (cand[k]) begin
        cand_hit = 1'b1;
        cand_g   = GW'(k);
      end
    end
  end

  always_comb begin
    dec_g = '0;
    for (int k = 1; k < GROUPS; k++) begin
      if ({1'b0, bn} >= (BLKIN_W+1)'(k * BLOCKS_PER_GROUP)) begin
        dec_g = GW'(k);
      end
    end
    dec_base = BLKIN_W'(dec_g) * BLKIN_W'(BLOCKS_PER_GROUP);
    dec_i    = IW'(bn - dec_base);
  end

  assign blk_full = BLKIN_W'(cur) * BLKIN_W'(BLOCKS_PER_GROUP) + BLKIN_W'(free_idx);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cur;
    unique case (state)
      S_IDLE: begin
        if (start && req_type == REQ_ALLOC && pg_ok && total_free != '0 && room[pg_idx]) begin
          rd_en   = 1'b1;
          rd_addr = pg_idx;
        end
      end
      S_DEC: begin
        rd_en   = 1'b1;
        rd_addr = dec_g;
      end
      S_SCAN: begin
        rd_en   = cand_hit;
        rd_addr = cand_g;
      end
      S_EVAL: begin
        rd_en = 1'b0;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    we     = 1'b0;
    wr_row = row_eff;
    wr_cnt = cnt_eff;
    if (state == S_EVAL) begin
      if (op == REQ_ALLOC) begin
        we     = free_hit;
        wr_row = row_eff | (BLOCKS_PER_GROUP'(1) << free_idx);
        wr_cnt = cnt_eff - CNT_W'(1);
      end else begin
        we     = row_eff[idx];
        wr_row = row_eff & ~(BLOCKS_PER_GROUP'(1) << idx);
        wr_cnt = (cnt_eff == CNT_MAX) ? cnt_eff : cnt_eff + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      row_mem[cur] <= wr_row;
      cnt_mem[cur] <= wr_cnt;
    end
    if (rd_en) begin
      rd_row <= row_mem[rd_addr];
      rd_cnt <= cnt_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      rd_valid   <= 1'b0;
      rvalid     <= '0;
      room       <= '1;
      cand       <= '0;
      fallback   <= 1'b0;
      total_free <= TOTAL_W'(TOTAL - 1);
    end else begin
      done <= 1'b0;
      if (rd_en) begin
        rd_valid <= rvalid[rd_addr];
      end
      if (we) begin
        rvalid[cur] <= 1'b1;
        room[cur]   <= (wr_cnt != '0);
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op <= req_type;
            if (req_type == REQ_ALLOC) begin
              if (!pg_ok) begin
                done        <= 1'b1;
                status      <= ST_BAD_GROUP;
                granted_blk <= '0;
              end else if (total_free == '0) begin
                done        <= 1'b1;
                status      <= ST_NO_SPACE;
                granted_blk <= '0;
              end else begin
                cur <= pg_idx;
                if (room[pg_idx]) begin
                  fallback <= 1'b0;
                  state    <= S_EVAL;
                end else begin
                  fallback <= 1'b1;
                  cand     <= room;
                  state    <= S_SCAN;
                end
              end
            end else begin
              if (target_blk == '0) begin
                done        <= 1'b1;
                status      <= ST_OK;
                granted_blk <= '0;
              end else if ({1'b0, target_blk} >= TOTAL_V) begin
                done        <= 1'b1;
                status      <= ST_OUT_OF_RANGE;
                granted_blk <= '0;
              end else begin
                bn    <= target_blk;
                state <= S_DEC;
              end
            end
          end
        end
        S_DEC: begin
          cur   <= dec_g;
          idx   <= dec_i;
          state <= S_EVAL;
        end
        S_SCAN: begin
          if (cand_hit) begin
            cur          <= cand_g;
            cand[cand_g] <= 1'b0;
            state        <= S_EVAL;
          end else begin
            done        <= 1'b1;
            status      <= ST_CORRUPT;
            granted_blk <= '0;
            state       <= S_IDLE;
          end
        end
        S_EVAL: begin
          if (op == REQ_ALLOC) begin
            if (free_hit) begin
              total_free  <= total_free - TOTAL_W'(1);
              done        <= 1'b1;
              status      <= ST_OK;
              granted_blk <= BLK_W'(blk_full);
              state       <= S_IDLE;
            end else begin
              if (!fallback) begin
                fallback <= 1'b1;
                cand     <= room;
              end
              state <= S_SCAN;
            end
          end else begin
            if (row_eff[idx] && total_free != TOT_MAX) begin
              total_free <= total_free + TOTAL_W'(1);
            end
            done        <= 1'b1;
            status      <= ST_OK;
            granted_blk <= '0;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* bench/block_alloc_checker.sv */
`timescale 1ns / 1ps

module block_alloc_checker
  import gbba_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic               req_type,
  input  logic [PG_W-1:0]    preferred_group,
  input  logic [BLKIN_W-1:0] target_blk,
  input  logic               done,
  input  status_t            status,
  input  logic [BLK_W-1:0]   granted_blk,
  output int                 errors,
  output int                 pending,
  output int                 free_left,
  output int                 n_alloc,
  output int                 n_freed,
  output int                 n_full,
  output int                 n_rejected
);

  localparam int NGRP = GROUPS_DEF;
  localparam int BPG  = BLOCKS_PER_GROUP_DEF;
  localparam int NBLK = NGRP * BPG;

  typedef struct packed {
    status_t          st;
    logic [BLK_W-1:0] blk;
  } grant_t;

  logic [BPG-1:0]     used_rows [NGRP];
  logic [CNT_W-1:0]   grp_free  [NGRP];
  logic [TOTAL_W-1:0] total_free;
  grant_t             expected_grants [$];

  int err_cnt, alloc_cnt, freed_cnt, full_cnt, reject_cnt;

  // lowest free bit of group g, if the group count says it has room
  task automatic take_from_group(input int g, inout bit got, inout logic [BLK_W-1:0] blk);
    if (!got && g < NGRP && grp_free[g] != '0) begin
      for (int i = 0; i < BPG && !got; i++) begin
        if (!used_rows[g][i]) begin
          used_rows[g][i] = 1'b1;
          grp_free[g]     = grp_free[g] - 1'b1;
          blk             = BLK_W'(g * BPG + i);
          got             = 1'b1;
        end
      end
    end
  endtask

  task automatic predict_grant(input logic rt, input logic [PG_W-1:0] pg,
                               input logic [BLKIN_W-1:0] bn, output grant_t res);
    bit               got;
    logic [BLK_W-1:0] blk;
    int               grp;
    int               idx;
    got     = 1'b0;
    blk     = '0;
    res.st  = ST_OK;
    if (rt == REQ_ALLOC) begin
      if (pg >= NGRP) begin
        res.st = ST_BAD_GROUP;
      end else if (total_free == '0) begin
        res.st = ST_NO_SPACE;
      end else begin
        take_from_group(int'(pg), got, blk);
        for (int g = 0; g < NGRP; g++) take_from_group(g, got, blk);
        if (got) begin
          total_free = total_free - 1'b1;
        end else begin
          res.st = ST_CORRUPT;
          blk    = '0;
        end
      end
    end else if (bn != '0) begin
      if (bn >= NBLK) begin
        res.st = ST_OUT_OF_RANGE;
      end else begin
        grp = int'(bn) / BPG;
        idx = int'(bn) % BPG;
        if (used_rows[grp][idx]) begin
          used_rows[grp][idx] = 1'b0;
          if (grp_free[grp] != '1) grp_free[grp] = grp_free[grp] + 1'b1;
          if (total_free != '1) total_free = total_free + 1'b1;
          freed_cnt++;
        end
      end
    end
    res.blk = blk;
  endtask

  always @(posedge clk) begin : monitor
    grant_t want;
    grant_t pred;
    if (rst) begin
      for (int g = 0; g < NGRP; g++) begin
        used_rows[g] = '0;
        grp_free[g]  = CNT_W'(BPG);
      end
      used_rows[0][0] = 1'b1;
      grp_free[0]     = CNT_W'(BPG - 1);
      total_free      = TOTAL_W'(NBLK - 1);
      expected_grants.delete();
      err_cnt    = 0;
      alloc_cnt  = 0;
      freed_cnt  = 0;
      full_cnt   = 0;
      reject_cnt = 0;
    end else begin
      if (done) begin
        if (expected_grants.size() == 0) begin
          $error("result with no request outstanding: status %0d, granted_blk %0d",
                 status, granted_blk);
          err_cnt++;
        end else begin
          want = expected_grants.pop_front();
          if (status !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, status);
            err_cnt++;
          end
          if (granted_blk !== want.blk) begin
            $error("granted_blk: expected %0d, got %0d", want.blk, granted_blk);
            err_cnt++;
          end
        end
      end
      if (start && !busy) begin
        predict_grant(req_type, preferred_group, target_blk, pred);
        expected_grants.push_back(pred);
        case (pred.st)
          ST_OK:           if (req_type == REQ_ALLOC) alloc_cnt++;
          ST_NO_SPACE:     full_cnt++;
          ST_BAD_GROUP,
          ST_OUT_OF_RANGE: reject_cnt++;
          default: ;
        endcase
      end
    end
    errors     <= err_cnt;
    pending    <= expected_grants.size();
    free_left  <= int'(total_free);
    n_alloc    <= alloc_cnt;
    n_freed    <= freed_cnt;
    n_full     <= full_cnt;
    n_rejected <= reject_cnt;
  end

endmodule

/* bench/grouped_block_bitmap_allocator_unit_tb.sv */
`timescale 1ns / 1ps

module grouped_block_bitmap_allocator_unit_tb;
  import gbba_pkg::*;

  localparam int NBLK = GROUPS_DEF * BLOCKS_PER_GROUP_DEF;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic               req_type;
  logic [PG_W-1:0]    preferred_group;
  logic [BLKIN_W-1:0] target_blk;
  logic               done;
  status_t            status;
  logic [BLK_W-1:0]   granted_blk;

  int errors, pending, free_left, n_alloc, n_freed, n_full, n_rejected;
  int sent;
  bit gaps_on;

  grouped_block_bitmap_allocator_unit u_top (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .req_type        (req_type),
    .preferred_group (preferred_group),
    .target_blk      (target_blk),
    .done            (done),
    .status          (status),
    .granted_blk     (granted_blk)
  );

  block_alloc_checker u_check (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .req_type        (req_type),
    .preferred_group (preferred_group),
    .target_blk      (target_blk),
    .done            (done),
    .status          (status),
    .granted_blk     (granted_blk),
    .errors          (errors),
    .pending         (pending),
    .free_left       (free_left),
    .n_alloc         (n_alloc),
    .n_freed         (n_freed),
    .n_full          (n_full),
    .n_rejected      (n_rejected)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_request(input logic rt, input logic [PG_W-1:0] pg,
                              input logic [BLKIN_W-1:0] bn);
    @(negedge clk);
    start           <= 1'b1;
    req_type        <= rt;
    preferred_group <= pg;
    target_blk      <= bn;
    do @(posedge clk); while (busy);
    sent++;
    // idle bursts, with every third stretch of 64 requests left back to back
    if (gaps_on && (sent / 64) % 3 != 2 && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 5)) begin
        @(negedge clk);
        start <= 1'b0;
      end
    end
  endtask

  // reach bounds the in-group index of frees aimed at likely used blocks;
  // pg_hi bounds the preferred group of most allocates
  task automatic random_request(input int alloc_pct, input int reach, input int pg_hi);
    logic [PG_W-1:0]    pg;
    logic [BLKIN_W-1:0] bn;
    int                 kind;
    pg = PG_W'($urandom);
    bn = BLKIN_W'($urandom);
    if ($urandom_range(0, 99) < alloc_pct) begin
      if ($urandom_range(0, 9) != 0) pg = PG_W'($urandom_range(0, pg_hi));
      send_request(REQ_ALLOC, pg, bn);
    end else begin
      kind = $urandom_range(0, 19);
      if (kind == 0)
        bn = '0;
      else if (kind == 1)
        bn = BLKIN_W'($urandom_range(NBLK, 2**BLKIN_W - 1));
      else if (kind > 2)
        bn = BLKIN_W'($urandom_range(0, GROUPS_DEF - 1) * BLOCKS_PER_GROUP_DEF
                      + $urandom_range(0, reach));
      send_request(REQ_FREE, pg, bn);
    end
  endtask

  initial begin
    rst             = 1'b1;
    start           = 1'b0;
    req_type        = REQ_ALLOC;
    preferred_group = '0;
    target_blk      = '0;
    gaps_on         = 1'b1;
    sent            = 0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    send_request(REQ_ALLOC, 4'd0,  12'd0);
    send_request(REQ_ALLOC, 4'd7,  12'd4095);
    send_request(REQ_ALLOC, 4'd8,  12'd0);
    send_request(REQ_ALLOC, 4'd15, 12'd4095);
    send_request(REQ_ALLOC, 4'd3,  12'd0);
    send_request(REQ_FREE,  4'd0,  12'd0);
    send_request(REQ_FREE,  4'd15, 12'd4095);
    send_request(REQ_FREE,  4'd0,  12'd2048);
    send_request(REQ_FREE,  4'd0,  12'd2047);
    send_request(REQ_FREE,  4'd7,  12'd1792);
    send_request(REQ_FREE,  4'd7,  12'd1792);
    send_request(REQ_FREE,  4'd0,  12'd1);
    send_request(REQ_ALLOC, 4'd0,  12'd0);
    send_request(REQ_ALLOC, 4'd5,  12'd2730);
    send_request(REQ_FREE,  4'd10, 12'd1365);
    send_request(REQ_FREE,  4'd4,  12'd768);
    send_request(REQ_ALLOC, 4'd3,  12'd1365);

    repeat (150) random_request(65, 63, GROUPS_DEF - 1);
    // crowd the low groups so they run out and fallback gets exercised
    repeat (1100) random_request(96, BLOCKS_PER_GROUP_DEF - 1, GROUPS_DEF / 4);
    repeat (180) random_request(60, BLOCKS_PER_GROUP_DEF - 1, GROUPS_DEF - 1);
    gaps_on = 1'b0;
    repeat (100) random_request(30, BLOCKS_PER_GROUP_DEF - 1, GROUPS_DEF - 1);

    @(negedge clk);
    start <= 1'b0;
    wait (pending == 0);
    repeat (20) @(posedge clk);

    $display("%0d requests: %0d blocks granted, %0d released, %0d refused on a full map,",
             sent, n_alloc, n_freed, n_full);
    $display("%0d rejected for a bad group or a block number out of range", n_rejected);
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

/* filelist.f */
src/gbba_pkg.sv
src/grouped_block_bitmap_allocator_unit.sv
bench/block_alloc_checker.sv
bench/grouped_block_bitmap_allocator_unit_tb.sv
